// ----- rtl/tld_pkg.sv -----
package tld_pkg;

  localparam int DEPTH      = 1024;
  localparam int AW         = 10;
  localparam int CW         = 11;
  localparam int MW         = 7;
  localparam int READ_CHUNK = 64;

  // result kinds
  localparam logic [2:0] K_ECHO     = 3'd0;
  localparam logic [2:0] K_OUT      = 3'd1;
  localparam logic [2:0] K_READ     = 3'd2;
  localparam logic [2:0] K_SIG      = 3'd3;
  localparam logic [2:0] K_DONE     = 3'd4;
  localparam logic [2:0] K_NOTREADY = 3'd5;
  localparam logic [2:0] K_REFUSED  = 3'd6;
  localparam logic [2:0] K_OVERFLOW = 3'd7;

  // operations
  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // receive classes
  localparam logic [1:0] CL_DONE = 2'd0;
  localparam logic [1:0] CL_SIG  = 2'd1;
  localparam logic [1:0] CL_EDIT = 2'd2;
  localparam logic [1:0] CL_PUSH = 2'd3;

  // edit actions
  localparam logic [1:0] ACT_ERASE = 2'd0;
  localparam logic [1:0] ACT_KILL  = 2'd1;
  localparam logic [1:0] ACT_WORD  = 2'd2;

  // queue read address sources
  localparam logic [1:0] RS_BACK = 2'd0;
  localparam logic [1:0] RS_FWD  = 2'd1;
  localparam logic [1:0] RS_PTR  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_SIG  = 3'd1;
  localparam logic [2:0] REG_EDIT = 3'd2;
  localparam logic [2:0] REG_LINE = 3'd3;
  localparam logic [2:0] REG_MIN  = 3'd4;

  // mode flag bits
  localparam int F_ICANON = 0;
  localparam int F_ISIG   = 1;
  localparam int F_IEXTEN = 2;
  localparam int F_ECHO   = 3;
  localparam int F_ECHOE  = 4;
  localparam int F_ECHOK  = 5;
  localparam int F_ECHONL = 6;
  localparam int F_ISTRIP = 7;
  localparam int F_IUCLC  = 8;
  localparam int F_IGNCR  = 9;
  localparam int F_ICRNL  = 10;
  localparam int F_INLCR  = 11;
  localparam int F_OPOST  = 12;
  localparam int F_ONLCR  = 13;
  localparam int F_OCRNL  = 14;
  localparam int F_OLCUC  = 15;

  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] STRIP_MASK = 8'h7F;

  typedef struct packed {
    logic           latch;
    logic           scan_clr;
    logic           scan_step;
    logic           eb_check;
    logic           eb_end;
    logic           push;
    logic           edit_apply;
    logic           read_start;
    logic           read_raw;
    logic           rd_next;
    logic           mem_rd;
    logic [1:0]     rd_src;
    logic           emit;
    logic [2:0]     kind;
    logic           second;
    logic           last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       max_zero;
    logic       icanon;
    logic [1:0] cls;
    logic       full;
    logic       echo_en;
    logic       edit_echo_en;
    logic       po_two;
    logic       scan_end;
    logic       eb_stop;
    logic       n_zero;
    logic       mark;
    logic       raw_notready;
    logic       count_zero;
    logic       k_one;
    logic       out_free;
  } sts_t;

  function automatic logic char_hit(input logic [7:0] c, input logic [7:0] ch);
    return (c != 8'd0) && (c == ch);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic po_two(input logic [15:0] f, input logic [7:0] ch);
    return f[F_OPOST] && f[F_ONLCR] && (ch == CH_NL);
  endfunction

  function automatic logic [7:0] po_byte(input logic [15:0] f, input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (f[F_OPOST]) begin
      if (f[F_ONLCR] && ch == CH_NL) r = CH_CR;
      else if (f[F_OCRNL] && ch == CH_CR) r = CH_NL;
      else if (f[F_OLCUC] && ch >= 8'h61 && ch <= 8'h7A) r = ch - 8'd32;
    end
    return r;
  endfunction

endpackage

// ----- rtl/tld_ctrl.sv -----
module tld_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tld_pkg::sts_t sts,
  output tld_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_EMIT1    = 4'd2;
  localparam logic [3:0] S_ECHO1    = 4'd3;
  localparam logic [3:0] S_ECHO2    = 4'd4;
  localparam logic [3:0] S_EB_RD    = 4'd5;
  localparam logic [3:0] S_EB_CK    = 4'd6;
  localparam logic [3:0] S_EB_APPLY = 4'd7;
  localparam logic [3:0] S_FW_RD    = 4'd8;
  localparam logic [3:0] S_FW_CK    = 4'd9;
  localparam logic [3:0] S_RD_RD    = 4'd10;
  localparam logic [3:0] S_RD_EMIT  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [2:0] echo_kind;

  assign in_tready = (state_r == S_IDLE);
  assign echo_kind = (sts.op == tld_pkg::OP_WRITE) ? tld_pkg::K_OUT : tld_pkg::K_ECHO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= tld_pkg::K_DONE;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        kind_nxt  = tld_pkg::K_DONE;
        state_nxt = S_EMIT1;
        case (sts.op)
          tld_pkg::OP_RECV: begin
            case (sts.cls)
              tld_pkg::CL_SIG: kind_nxt = tld_pkg::K_SIG;
              tld_pkg::CL_EDIT: begin
                cmd.scan_clr = 1'b1;
                state_nxt    = S_EB_RD;
              end
              tld_pkg::CL_PUSH: begin
                if (sts.full) begin
                  kind_nxt = tld_pkg::K_OVERFLOW;
                end else begin
                  cmd.push = 1'b1;
                  if (sts.echo_en) state_nxt = S_ECHO1;
                end
              end
              default: ;
            endcase
          end
          tld_pkg::OP_READ: begin
            if (sts.max_zero) begin
              kind_nxt = tld_pkg::K_DONE;
            end else if (sts.icanon) begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_FW_RD;
            end else if (sts.raw_notready) begin
              kind_nxt = tld_pkg::K_NOTREADY;
            end else if (!sts.count_zero) begin
              cmd.read_start = 1'b1;
              cmd.read_raw   = 1'b1;
              state_nxt      = S_RD_RD;
            end
          end
          tld_pkg::OP_WRITE: begin
            if (sts.full) kind_nxt = tld_pkg::K_REFUSED;
            else state_nxt = S_ECHO1;
          end
          default: ;
        endcase
      end
      S_EMIT1: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = kind_r;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ECHO1: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = echo_kind;
          cmd.last  = !sts.po_two;
          state_nxt = sts.po_two ? S_ECHO2 : S_IDLE;
        end
      end
      S_ECHO2: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = echo_kind;
          cmd.second = 1'b1;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EB_RD: begin
        if (sts.scan_end) begin
          cmd.eb_end = 1'b1;
          state_nxt  = S_EB_APPLY;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_src = tld_pkg::RS_BACK;
          state_nxt  = S_EB_CK;
        end
      end
      S_EB_CK: begin
        cmd.eb_check = 1'b1;
        state_nxt    = sts.eb_stop ? S_EB_APPLY : S_EB_RD;
      end
      S_EB_APPLY: begin
        kind_nxt = tld_pkg::K_DONE;
        if (sts.n_zero) begin
          state_nxt = S_EMIT1;
        end else begin
          cmd.edit_apply = 1'b1;
          state_nxt      = sts.edit_echo_en ? S_ECHO1 : S_EMIT1;
        end
      end
      S_FW_RD: begin
        if (sts.scan_end) begin
          kind_nxt  = tld_pkg::K_NOTREADY;
          state_nxt = S_EMIT1;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_src = tld_pkg::RS_FWD;
          state_nxt  = S_FW_CK;
        end
      end
      S_FW_CK: begin
        if (sts.mark) begin
          cmd.read_start = 1'b1;
          state_nxt      = S_RD_RD;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_FW_RD;
        end
      end
      S_RD_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_src = tld_pkg::RS_PTR;
        state_nxt  = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = tld_pkg::K_READ;
          cmd.last    = sts.k_one;
          cmd.rd_next = 1'b1;
          state_nxt   = sts.k_one ? S_IDLE : S_RD_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/tld_dp.sv -----
module tld_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [23:0]   cfg_wdata,
  input  logic [15:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          out_tready,
  output logic          out_tvalid,
  output logic [23:0]   out_tdata,
  output logic [2:0]    out_tuser,
  output logic          out_tlast,
  input  tld_pkg::cmd_t cmd,
  output tld_pkg::sts_t sts
);

  localparam int AW = tld_pkg::AW;
  localparam int CW = tld_pkg::CW;
  localparam int MW = tld_pkg::MW;

  logic [15:0] mode_r;
  logic [23:0] sigc_r, editc_r, linec_r;
  logic [CW-1:0] min_r;

  logic [1:0]    op_r;
  logic [7:0]    byte_r;
  logic [MW-1:0] max_r;

  logic [AW-1:0] head_r, tail_r, rp_r;
  logic [CW-1:0] count_r, i_r, n_r;
  logic          phase_r;
  logic [MW-1:0] k_r;

  logic [8:0] mem [tld_pkg::DEPTH];
  logic [8:0] rdata_r;

  logic          ov_r;
  logic [2:0]    o_kind_r;
  logic [7:0]    o_byte_r;
  logic [1:0]    o_sig_r;
  logic          o_le_r, o_last_r;
  logic [CW-1:0] o_q_r;

  // input mapping
  logic [7:0] s1, s2, m, pb, eb, pob;
  logic       drop, pm, echo_en, ed_echo;
  logic [1:0] cls, act, sig;

  logic [MW-1:0] maxc, k_fw, k_raw, k_sel;
  logic [CW-1:0] len_fw, cnt_rd, cnt_ed;
  logic [AW-1:0] addr;
  logic          rd_mark, rd_blank, eb_stop;
  logic [CW-1:0] nval;
  logic [7:0]    obyte;

  always_comb begin
    s1   = mode_r[tld_pkg::F_ISTRIP] ? (byte_r & tld_pkg::STRIP_MASK) : byte_r;
    s2   = (mode_r[tld_pkg::F_IUCLC] && mode_r[tld_pkg::F_IEXTEN] &&
            s1 >= 8'h41 && s1 <= 8'h5A) ? s1 + 8'd32 : s1;
    drop = (s2 == tld_pkg::CH_CR) && mode_r[tld_pkg::F_IGNCR];
    if (s2 == tld_pkg::CH_CR && mode_r[tld_pkg::F_ICRNL]) m = tld_pkg::CH_NL;
    else if (s2 == tld_pkg::CH_NL && mode_r[tld_pkg::F_INLCR]) m = tld_pkg::CH_CR;
    else m = s2;

    cls     = tld_pkg::CL_PUSH;
    pb      = m;
    pm      = 1'b0;
    echo_en = mode_r[tld_pkg::F_ECHO];
    act     = tld_pkg::ACT_ERASE;
    sig     = 2'd0;
    if (!mode_r[tld_pkg::F_ICANON]) begin
      pb = byte_r;
    end else if (drop) begin
      cls = tld_pkg::CL_DONE;
    end else if (mode_r[tld_pkg::F_ISIG] && tld_pkg::char_hit(sigc_r[7:0], m)) begin
      cls = tld_pkg::CL_SIG;
      sig = 2'd1;
    end else if (mode_r[tld_pkg::F_ISIG] && tld_pkg::char_hit(sigc_r[15:8], m)) begin
      cls = tld_pkg::CL_SIG;
      sig = 2'd2;
    end else if (mode_r[tld_pkg::F_ISIG] && tld_pkg::char_hit(sigc_r[23:16], m)) begin
      cls = tld_pkg::CL_SIG;
      sig = 2'd3;
    end else if (tld_pkg::char_hit(editc_r[23:16], m) && mode_r[tld_pkg::F_IEXTEN]) begin
      cls = tld_pkg::CL_EDIT;
      act = tld_pkg::ACT_WORD;
    end else if (tld_pkg::char_hit(editc_r[15:8], m)) begin
      cls = tld_pkg::CL_EDIT;
      act = tld_pkg::ACT_KILL;
    end else if (tld_pkg::char_hit(editc_r[7:0], m)) begin
      cls = tld_pkg::CL_EDIT;
    end else if (tld_pkg::char_hit(linec_r[7:0], m)) begin
      pb      = 8'd0;
      pm      = 1'b1;
      echo_en = 1'b0;
    end else if (m == tld_pkg::CH_NL) begin
      pm      = 1'b1;
      echo_en = mode_r[tld_pkg::F_ECHO] | mode_r[tld_pkg::F_ECHONL];
    end else if (tld_pkg::char_hit(linec_r[15:8], m) ||
                 (tld_pkg::char_hit(linec_r[23:16], m) && mode_r[tld_pkg::F_IEXTEN])) begin
      pm = 1'b1;
    end
    ed_echo = mode_r[tld_pkg::F_ECHO] &&
              ((act == tld_pkg::ACT_KILL) ? mode_r[tld_pkg::F_ECHOK] : mode_r[tld_pkg::F_ECHOE]);
    // raw receive echoes the byte as it came in
    eb  = (op_r == tld_pkg::OP_WRITE || !mode_r[tld_pkg::F_ICANON]) ? byte_r : m;
    pob = tld_pkg::po_byte(mode_r, eb);
  end

  // read sizing
  always_comb begin
    maxc   = (max_r > MW'(tld_pkg::READ_CHUNK)) ? MW'(tld_pkg::READ_CHUNK) : max_r;
    len_fw = i_r + CW'(1);
    k_fw   = (len_fw > CW'(maxc)) ? maxc : len_fw[MW-1:0];
    k_raw  = (count_r > CW'(maxc)) ? maxc : count_r[MW-1:0];
    k_sel  = cmd.read_raw ? k_raw : k_fw;
    cnt_rd = count_r - CW'(k_sel);
    cnt_ed = count_r - n_r;
  end

  always_comb begin
    case (cmd.rd_src)
      tld_pkg::RS_BACK: addr = tail_r - AW'(1) - i_r[AW-1:0];
      tld_pkg::RS_FWD:  addr = head_r + i_r[AW-1:0];
      default:          addr = rp_r;
    endcase
  end

  // edit scan stop test on the entry just read
  always_comb begin
    rd_mark  = rdata_r[8];
    rd_blank = tld_pkg::is_blank(rdata_r[7:0]);
    case (act)
      tld_pkg::ACT_ERASE: begin
        eb_stop = 1'b1;
        nval    = rd_mark ? CW'(0) : CW'(1);
      end
      tld_pkg::ACT_KILL: begin
        eb_stop = rd_mark;
        nval    = i_r;
      end
      tld_pkg::ACT_WORD: begin
        eb_stop = rd_mark || (phase_r && rd_blank);
        nval    = i_r;
      end
      default: begin
        eb_stop = 1'b1;
        nval    = CW'(0);
      end
    endcase
  end

  always_comb begin
    case (cmd.kind)
      tld_pkg::K_ECHO, tld_pkg::K_OUT: obyte = cmd.second ? tld_pkg::CH_NL : pob;
      tld_pkg::K_READ:                 obyte = rdata_r[7:0];
      tld_pkg::K_OVERFLOW:             obyte = pb;
      default:                         obyte = 8'd0;
    endcase
  end

  assign sts.op           = op_r;
  assign sts.max_zero     = (max_r == MW'(0));
  assign sts.icanon       = mode_r[tld_pkg::F_ICANON];
  assign sts.cls          = cls;
  assign sts.full         = (count_r == CW'(tld_pkg::DEPTH));
  assign sts.echo_en      = echo_en;
  assign sts.edit_echo_en = ed_echo;
  assign sts.po_two       = tld_pkg::po_two(mode_r, eb);
  assign sts.scan_end     = (i_r == count_r);
  assign sts.eb_stop      = eb_stop;
  assign sts.n_zero       = (n_r == CW'(0));
  assign sts.mark         = rd_mark;
  assign sts.raw_notready = (count_r < min_r);
  assign sts.count_zero   = (count_r == CW'(0));
  assign sts.k_one        = (k_r == MW'(1));
  assign sts.out_free     = !ov_r || out_tready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 16'd13375;
      sigc_r  <= 24'd1711107;
      editc_r <= 24'd1512831;
      linec_r <= 24'd4;
      min_r   <= CW'(1);
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          tld_pkg::REG_MODE: mode_r  <= cfg_wdata[15:0];
          tld_pkg::REG_SIG:  sigc_r  <= cfg_wdata;
          tld_pkg::REG_EDIT: editc_r <= cfg_wdata;
          tld_pkg::REG_LINE: linec_r <= cfg_wdata;
          tld_pkg::REG_MIN:  min_r   <= cfg_wdata[CW-1:0];
          default: ;
        endcase
      end
      if (cmd.push) begin
        tail_r  <= tail_r + AW'(1);
        count_r <= count_r + CW'(1);
      end
      if (cmd.edit_apply) begin
        count_r <= cnt_ed;
        if (cnt_ed == CW'(0)) begin
          head_r <= '0;
          tail_r <= '0;
        end else begin
          tail_r <= tail_r - n_r[AW-1:0];
        end
      end
      if (cmd.read_start) begin
        count_r <= cnt_rd;
        if (cnt_rd == CW'(0)) begin
          head_r <= '0;
          tail_r <= '0;
        end else begin
          head_r <= head_r + AW'(k_sel);
        end
      end
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_tuser;
      byte_r <= in_tdata[7:0];
      max_r  <= in_tdata[14:8];
    end
    if (cmd.scan_clr) begin
      i_r     <= '0;
      phase_r <= 1'b0;
    end
    if (cmd.scan_step) i_r <= i_r + CW'(1);
    if (cmd.eb_check) begin
      if (eb_stop) begin
        n_r <= nval;
      end else begin
        i_r <= i_r + CW'(1);
        if (!rd_blank) phase_r <= 1'b1;
      end
    end
    if (cmd.eb_end) n_r <= i_r;
    if (cmd.read_start) begin
      rp_r <= head_r;
      k_r  <= k_sel;
    end
    if (cmd.rd_next) begin
      rp_r <= rp_r + AW'(1);
      k_r  <= k_r - MW'(1);
    end
    if (cmd.emit) begin
      o_kind_r <= cmd.kind;
      o_byte_r <= obyte;
      o_sig_r  <= (cmd.kind == tld_pkg::K_SIG) ? sig : 2'd0;
      o_le_r   <= (cmd.kind == tld_pkg::K_READ) ? rdata_r[8] : 1'b0;
      o_q_r    <= count_r;
      o_last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) mem[tail_r] <= {pm, pb};
    if (cmd.mem_rd) rdata_r <= mem[addr];
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_q_r, o_le_r, o_sig_r, o_byte_r};

endmodule

// ----- rtl/tty_line_discipline_unit.sv -----
// Channel  Ports            Content (lowest bit up)
// in       in_t*            tuser: op; tdata: data_byte, read_max
// out      out_t*           tuser: kind; tdata: out_byte, signal_code, line_end, queued
// cfg      cfg_we/addr/...  register index and write data
//
// One item at a time: decode runs first, then each result in turn.
// Erase and canonical read walk the 1024-entry queue memory one entry at a time
// (registered read port), at most over all queued bytes when no line end stops
// the walk; each read byte is fetched, then emitted. Reset is synchronous,
// active low, clears head, tail, count and output valid and loads the
// configuration defaults; queue memory contents are not cleared.
// A stalled output holds the pending result while the next item may enter.
module tty_line_discipline_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [14:8] read_max
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [9:8] signal_code, [10] line_end,
                                  // [21:11] queued
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);

  tld_pkg::cmd_t cmd;
  tld_pkg::sts_t sts;

  // sequencer: walks decode, queue scans and result emission
  tld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // queue memory, pointers, mode registers and the output register
  tld_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

  // One expected or observed result item of the line discipline.
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [1:0]  sig;
    logic        line_end;
    logic [10:0] queued;
    logic        last;
  } tty_res_t;

  // Scoreboard: carries its own copy of the line discipline (queue, line-end
  // marks, registers) and the FIFO of results still owed by the block.
  class TtyScoreboard;
    logic [15:0] mode;
    logic [23:0] sig_chars, edit_chars, line_chars;
    logic [10:0] min_count;
    logic [7:0]  store [tld_pkg::DEPTH];
    bit          eol_mark [tld_pkg::DEPTH];
    int          head, tail, count;
    tty_res_t    owed [$];
    tty_res_t    step_res [$];
    int          errors;

    function void reset_state();
      mode = 16'd13375; sig_chars = 24'd1711107; edit_chars = 24'd1512831;
      line_chars = 24'd4; min_count = 11'd1;
      head = 0; tail = 0; count = 0; errors = 0;
      foreach (eol_mark[i]) eol_mark[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        tld_pkg::REG_MODE: mode = val[15:0];
        tld_pkg::REG_SIG:  sig_chars = val;
        tld_pkg::REG_EDIT: edit_chars = val;
        tld_pkg::REG_LINE: line_chars = val;
        tld_pkg::REG_MIN:  min_count = val[10:0];
        default: ;
      endcase
    endfunction

    function bit hit(logic [23:0] r, int slot, logic [7:0] ch);
      logic [7:0] c;
      c = r[8*slot +: 8];
      return (c != 8'd0) && (c == ch);
    endfunction

    function bit blank(logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void add(logic [2:0] k, logic [7:0] b, logic [1:0] s, logic le);
      tty_res_t r;
      if (step_res.size() >= tld_pkg::READ_CHUNK) return;
      r.kind = k; r.data = b; r.sig = s; r.line_end = le; r.queued = '0; r.last = 1'b0;
      step_res.push_back(r);
    endfunction

    // output post-processing for echoed and written bytes
    function void post_proc(logic [2:0] k, logic [7:0] ch);
      if (!mode[tld_pkg::F_OPOST]) add(k, ch, 2'd0, 1'b0);
      else if (mode[tld_pkg::F_ONLCR] && ch == tld_pkg::CH_NL) begin
        add(k, tld_pkg::CH_CR, 2'd0, 1'b0);
        add(k, tld_pkg::CH_NL, 2'd0, 1'b0);
      end else if (mode[tld_pkg::F_OCRNL] && ch == tld_pkg::CH_CR)
        add(k, tld_pkg::CH_NL, 2'd0, 1'b0);
      else begin
        if (mode[tld_pkg::F_OLCUC] && ch >= "a" && ch <= "z") ch = ch - 8'd32;
        add(k, ch, 2'd0, 1'b0);
      end
    endfunction

    function bit enqueue(logic [7:0] b, bit m);
      if (count >= tld_pkg::DEPTH) begin
        add(tld_pkg::K_OVERFLOW, b, 2'd0, 1'b0);
        return 0;
      end
      store[tail] = b; eol_mark[tail] = m;
      tail = (tail + 1) % tld_pkg::DEPTH;
      count++;
      return 1;
    endfunction

    function int back_at(int i);
      return (tail + tld_pkg::DEPTH - 1 - i) % tld_pkg::DEPTH;
    endfunction

    function void edit_line(logic [7:0] ch, logic [1:0] act);
      int len, n;
      len = 0; n = 0;
      while (len < count && !eol_mark[back_at(len)]) len++;
      if (len == 0) return;
      if (act == tld_pkg::ACT_KILL) n = len;
      else if (act == tld_pkg::ACT_WORD) begin
        while (n < len && blank(store[back_at(n)])) n++;
        while (n < len && !blank(store[back_at(n)])) n++;
      end else n = 1;
      if (mode[tld_pkg::F_ECHO] &&
          (act == tld_pkg::ACT_KILL ? mode[tld_pkg::F_ECHOK] : mode[tld_pkg::F_ECHOE]))
        post_proc(tld_pkg::K_ECHO, ch);
      tail = (tail + tld_pkg::DEPTH - n) % tld_pkg::DEPTH;
      count -= n;
      if (count == 0) begin head = 0; tail = 0; end
    endfunction

    function void receive(logic [7:0] ch);
      logic [1:0] s;
      if (!mode[tld_pkg::F_ICANON]) begin
        if (enqueue(ch, 1'b0) && mode[tld_pkg::F_ECHO]) post_proc(tld_pkg::K_ECHO, ch);
        return;
      end
      if (mode[tld_pkg::F_ISTRIP]) ch = ch & tld_pkg::STRIP_MASK;
      if (mode[tld_pkg::F_IUCLC] && mode[tld_pkg::F_IEXTEN] && ch >= "A" && ch <= "Z")
        ch = ch + 8'd32;
      if (ch == tld_pkg::CH_CR) begin
        if (mode[tld_pkg::F_IGNCR]) return;
        if (mode[tld_pkg::F_ICRNL]) ch = tld_pkg::CH_NL;
      end else if (ch == tld_pkg::CH_NL && mode[tld_pkg::F_INLCR]) ch = tld_pkg::CH_CR;
      if (mode[tld_pkg::F_ISIG]) begin
        s = hit(sig_chars, 0, ch) ? 2'd1 : hit(sig_chars, 1, ch) ? 2'd2 :
            hit(sig_chars, 2, ch) ? 2'd3 : 2'd0;
        if (s != 2'd0) begin
          add(tld_pkg::K_SIG, 8'd0, s, 1'b0);
          return;
        end
      end
      if (hit(edit_chars, 2, ch) && mode[tld_pkg::F_IEXTEN]) begin
        edit_line(ch, tld_pkg::ACT_WORD);
        return;
      end
      if (hit(edit_chars, 1, ch)) begin edit_line(ch, tld_pkg::ACT_KILL); return; end
      if (hit(edit_chars, 0, ch)) begin edit_line(ch, tld_pkg::ACT_ERASE); return; end
      if (hit(line_chars, 0, ch)) begin void'(enqueue(8'd0, 1'b1)); return; end
      if (ch == tld_pkg::CH_NL) begin
        if (enqueue(ch, 1'b1) && (mode[tld_pkg::F_ECHO] || mode[tld_pkg::F_ECHONL]))
          post_proc(tld_pkg::K_ECHO, ch);
        return;
      end
      if (hit(line_chars, 1, ch) || (hit(line_chars, 2, ch) && mode[tld_pkg::F_IEXTEN])) begin
        if (enqueue(ch, 1'b1) && mode[tld_pkg::F_ECHO]) post_proc(tld_pkg::K_ECHO, ch);
        return;
      end
      if (enqueue(ch, 1'b0) && mode[tld_pkg::F_ECHO]) post_proc(tld_pkg::K_ECHO, ch);
    endfunction

    function void read_line(int lim);
      int len, k, p;
      bit found;
      len = 0; found = 0;
      if (lim > tld_pkg::READ_CHUNK) lim = tld_pkg::READ_CHUNK;
      if (mode[tld_pkg::F_ICANON]) begin
        for (int i = 0; i < count && !found; i++)
          if (eol_mark[(head + i) % tld_pkg::DEPTH]) begin
            len = i + 1;
            found = 1;
          end
        if (!found) begin add(tld_pkg::K_NOTREADY, 8'd0, 2'd0, 1'b0); return; end
      end else begin
        if (count < min_count) begin add(tld_pkg::K_NOTREADY, 8'd0, 2'd0, 1'b0); return; end
        len = count;
      end
      k = (len < lim) ? len : lim;
      if (k == 0) begin add(tld_pkg::K_DONE, 8'd0, 2'd0, 1'b0); return; end
      for (int i = 0; i < k; i++) begin
        p = (head + i) % tld_pkg::DEPTH;
        add(tld_pkg::K_READ, store[p], 2'd0, eol_mark[p]);
      end
      count -= k;
      if (count == 0) begin head = 0; tail = 0; end
      else head = (head + k) % tld_pkg::DEPTH;
    endfunction

    // note one accepted input item and queue the results it owes
    function void note_item(logic [1:0] op, logic [7:0] b, logic [6:0] lim);
      step_res.delete();
      case (op)
        tld_pkg::OP_RECV:  receive(b);
        tld_pkg::OP_READ:
          if (lim == 7'd0) add(tld_pkg::K_DONE, 8'd0, 2'd0, 1'b0); else read_line(lim);
        tld_pkg::OP_WRITE:
          if (count >= tld_pkg::DEPTH) add(tld_pkg::K_REFUSED, 8'd0, 2'd0, 1'b0);
          else post_proc(tld_pkg::K_OUT, b);
        default: ;
      endcase
      if (step_res.size() == 0) add(tld_pkg::K_DONE, 8'd0, 2'd0, 1'b0);
      foreach (step_res[i]) begin
        step_res[i].queued = count[10:0];
        step_res[i].last = (i == step_res.size() - 1);
        owed.push_back(step_res[i]);
      end
    endfunction

    function void check_result(tty_res_t got);
      tty_res_t e;
      if (owed.size() == 0) begin
        $error("unexpected result kind=%0d byte=%0h", got.kind, got.data);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.data !== e.data) begin
        $error("out_byte expected %0h actual %0h", e.data, got.data); errors++;
      end
      if (got.sig !== e.sig) begin
        $error("signal_code expected %0d actual %0d", e.sig, got.sig); errors++;
      end
      if (got.line_end !== e.line_end) begin
        $error("line_end expected %0d actual %0d", e.line_end, got.line_end); errors++;
      end
      if (got.queued !== e.queued) begin
        $error("queued expected %0d actual %0d", e.queued, got.queued); errors++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0d actual %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;   // cycles without any handshake
  localparam int LONG_HOLD   = 300;     // receiver back-pressure stretch

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  TtyScoreboard sb = new();
  bit  long_hold = 0;     // main asks the receiver for one long hold-off
  bit  calm_out = 0;      // receiver runs without stalls while set
  int  idle_cycles = 0;

  tty_line_discipline_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Watchdog: end the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall for a random count before each item (none while calm_out is
  // set), or for a long stretch when asked, then take the item and check it.
  initial begin
    tty_res_t got;
    int hold;
    @(posedge rst_n);
    forever begin
      hold = long_hold ? LONG_HOLD : (calm_out ? 0 : $urandom_range(0, 15));
      long_hold = 0;
      if (hold > 0) begin
        out_tready <= 0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      got.kind = out_tuser; got.data = out_tdata[7:0]; got.sig = out_tdata[9:8];
      got.line_end = out_tdata[10]; got.queued = out_tdata[21:11]; got.last = out_tlast;
      sb.check_result(got);
    end
  end

  bit calm_in = 0;

  // Offer one item after a random gap; valid stays high across back-to-back items.
  task automatic send_item(logic [1:0] op, logic [7:0] b, logic [6:0] lim);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {1'b0, lim, b};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, b, lim);
  endtask

  // Drop valid and wait until every owed result is back, plus a margin.
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Mostly plausible typing with random content, some edits, signals and
  // line ends taken from the current setting, reads, writes and noise.
  task automatic random_item();
    int r;
    logic [23:0] pool;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: send_item(tld_pkg::OP_RECV, 8'd32, 7'd0);
        1: send_item(tld_pkg::OP_RECV, 8'($urandom_range("A", "Z")), 7'($urandom));
        default: send_item(tld_pkg::OP_RECV, 8'($urandom_range("a", "z")), 7'($urandom));
      endcase
    end else if (r < 52)
      send_item(tld_pkg::OP_RECV, $urandom_range(0, 1) ? tld_pkg::CH_NL : tld_pkg::CH_CR,
                7'd0);
    else if (r < 60) begin
      case ($urandom_range(0, 2))
        0: pool = sb.sig_chars;
        1: pool = sb.edit_chars;
        default: pool = sb.line_chars;
      endcase
      send_item(tld_pkg::OP_RECV, pool[8*$urandom_range(0, 2) +: 8], 7'd0);
    end else if (r < 63) send_item(tld_pkg::OP_RECV, 8'($urandom), 7'($urandom));
    else if (r < 80) send_item(tld_pkg::OP_READ, 8'($urandom), 7'($urandom_range(1, 64)));
    else if (r < 83) send_item(tld_pkg::OP_READ, 8'($urandom), 7'($urandom));
    else if (r < 95) send_item(tld_pkg::OP_WRITE, 8'($urandom), 7'($urandom));
    else send_item(2'd3, 8'($urandom), 7'($urandom));
  endtask

  initial begin
    logic [15:0] modes [5];
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part under the reset setting: typing, each edit, signals,
    // end of file, reads short and cut, writes, unknown op, extreme bytes.
    send_item(tld_pkg::OP_RECV, "h", 7'd0);
    send_item(tld_pkg::OP_RECV, "e", 7'd0);
    send_item(tld_pkg::OP_RECV, " ", 7'd0);
    send_item(tld_pkg::OP_RECV, "x", 7'd0);
    send_item(tld_pkg::OP_RECV, 8'h7F, 7'd0);      // erase one
    send_item(tld_pkg::OP_RECV, 8'h17, 7'd0);      // erase word
    send_item(tld_pkg::OP_RECV, "Q", 7'd0);
    send_item(tld_pkg::OP_RECV, 8'h15, 7'd0);      // kill line
    send_item(tld_pkg::OP_RECV, 8'h15, 7'd0);      // kill on empty line
    send_item(tld_pkg::OP_RECV, "b", 7'd0);
    send_item(tld_pkg::OP_RECV, tld_pkg::CH_CR, 7'd0);  // mapped to newline, ends the line
    send_item(tld_pkg::OP_READ, 8'd0, 7'd1);
    send_item(tld_pkg::OP_READ, 8'd0, 7'd127);     // cut to the chunk size
    send_item(tld_pkg::OP_READ, 8'd0, 7'd64);      // nothing complete
    send_item(tld_pkg::OP_RECV, 8'h03, 7'd0);
    send_item(tld_pkg::OP_RECV, 8'h1C, 7'd0);
    send_item(tld_pkg::OP_RECV, 8'h1A, 7'd0);
    send_item(tld_pkg::OP_RECV, 8'h04, 7'd0);      // end of file
    send_item(tld_pkg::OP_READ, 8'hFF, 7'd0);
    send_item(tld_pkg::OP_READ, 8'd0, 7'd64);
    send_item(tld_pkg::OP_WRITE, "a", 7'd0);
    send_item(tld_pkg::OP_WRITE, tld_pkg::CH_NL, 7'd0);
    send_item(tld_pkg::OP_WRITE, 8'hFF, 7'h7F);
    send_item(2'd3, 8'hAA, 7'h55);
    send_item(tld_pkg::OP_RECV, 8'h00, 7'd0);
    drain();

    // Random phases, each under its own setting; extremes included.
    modes[0] = 16'h343F; modes[1] = 16'hFFFF; modes[2] = 16'h0000;
    modes[3] = 16'($urandom); modes[4] = 16'($urandom) | 16'h0001;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(tld_pkg::REG_MODE, {8'd0, modes[ph]});
      case (ph)
        1: begin
          write_reg(tld_pkg::REG_SIG, 24'hFFFFFF); write_reg(tld_pkg::REG_EDIT, 24'h17157F);
          write_reg(tld_pkg::REG_LINE, 24'h2E3B04); write_reg(tld_pkg::REG_MIN, 24'd1024);
        end
        2: begin
          write_reg(tld_pkg::REG_SIG, 24'h0); write_reg(tld_pkg::REG_EDIT, 24'h0);
          write_reg(tld_pkg::REG_LINE, 24'h0); write_reg(tld_pkg::REG_MIN, 24'd0);
        end
        default: begin
          write_reg(tld_pkg::REG_SIG, 24'h1A1C03 ^ (ph == 4 ? 24'($urandom) : 24'h0));
          write_reg(tld_pkg::REG_EDIT, ph == 4 ? 24'hFFFFFF : 24'h171508);
          write_reg(tld_pkg::REG_LINE, {8'($urandom_range("!", "~")), 8'h3B, 8'h04});
          write_reg(tld_pkg::REG_MIN, 24'($urandom_range(0, 20)));
        end
      endcase
      if (ph == 3) long_hold = 1;
      for (int i = 0; i < 80; i++) begin
        calm_in = (i % 40) < 8;
        calm_out = (i % 50) >= 40;
        random_item();
      end
      calm_in = 0; calm_out = 0;
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
